// File: hw/rtl/ttb_pkg.sv
// shared constants and types for the triangle tangent basis pipeline
// no dependencies; used by every module of the block
package ttb_pkg;

   localparam int COMPONENT_BITS_DEF = 16;
   localparam int POS_WIDTH = 48;
   localparam int TEX_WIDTH = 32;
   localparam int TEX_BITS = 16;
   localparam int OUT_BITS = 16;
   localparam int VEC_WIDTH = 3 * OUT_BITS;
   localparam int FRAC_BITS = 14;
   // tangent component width is component width plus this growth
   localparam int TAN_GROWTH = 19;
   localparam int MAG_BITS = 30;
   localparam int SUM_BITS = 2 * MAG_BITS + 2;
   localparam int SQRT_STEPS = MAG_BITS + 1;
   localparam int LEN_BITS = MAG_BITS + 1;
   localparam int DIV_STEPS = FRAC_BITS + 1;
   localparam int NUM_BITS = MAG_BITS + DIV_STEPS + 2;
   localparam int FRONT_LAT = 4;
   localparam int NORM_LAT = 5 + SQRT_STEPS + DIV_STEPS + 2;

   typedef struct packed {
      logic valid;
      logic det_zero;
   } ttb_ctl_type;

endpackage

// File: hw/rtl/ttb_front.sv
// front end: edges, texcoord deltas, cross terms, determinant sign/zero
// depends on ttb_pkg
module ttb_front #(
   parameter int COMPONENT_BITS = ttb_pkg::COMPONENT_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  adv,
   input  logic                                  in_valid,
   input  logic [ttb_pkg::POS_WIDTH-1:0]         pos_a,
   input  logic [ttb_pkg::POS_WIDTH-1:0]         pos_b,
   input  logic [ttb_pkg::POS_WIDTH-1:0]         pos_c,
   input  logic [ttb_pkg::TEX_WIDTH-1:0]         tex_a,
   input  logic [ttb_pkg::TEX_WIDTH-1:0]         tex_b,
   input  logic [ttb_pkg::TEX_WIDTH-1:0]         tex_c,
   output ttb_pkg::ttb_ctl_type                  ctl_out,
   output logic [3*(COMPONENT_BITS+ttb_pkg::TAN_GROWTH)-1:0] tan_out,
   output logic [3*(COMPONENT_BITS+ttb_pkg::TAN_GROWTH)-1:0] bit_out
);
   import ttb_pkg::*;

   localparam int CB = COMPONENT_BITS;
   localparam int DW = CB + 1;
   localparam int PW = CB + TAN_GROWTH - 1;
   localparam int VW = CB + TAN_GROWTH;
   localparam int TD = TEX_BITS + 1;
   localparam int PADW = (3 * CB > POS_WIDTH) ? 3 * CB : POS_WIDTH;

   logic [PADW-1:0] pad_a, pad_b, pad_c;

   logic              v1_ff;
   logic signed [DW-1:0] p_in [3], q_in [3], p_ff [3], q_ff [3];
   logic signed [TD-1:0] s1_in, t1_in, s2_in, t2_in, s1_ff, t1_ff, s2_ff, t2_ff;

   logic              v2_ff;
   logic signed [PW-1:0] ta_ff [3], tb_ff [3], ba_ff [3], bb_ff [3];
   logic signed [2*TD-1:0] d1_ff, d2_ff;

   logic              v3_ff, neg3_ff, zero3_ff;
   logic signed [PW-1:0] ta3_ff [3], tb3_ff [3], ba3_ff [3], bb3_ff [3];
   logic signed [2*TD:0] det;

   logic              v4_ff, zero4_ff;
   logic signed [VW-1:0] tan_ff [3], bit_ff [3];

   assign pad_a = PADW'(pos_a);
   assign pad_b = PADW'(pos_b);
   assign pad_c = PADW'(pos_c);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p_in[i] = DW'($signed(pad_b[i*CB +: CB])) - DW'($signed(pad_a[i*CB +: CB]));
         q_in[i] = DW'($signed(pad_c[i*CB +: CB])) - DW'($signed(pad_a[i*CB +: CB]));
      end
      s1_in = $signed({1'b0, tex_b[TEX_BITS-1:0]}) - $signed({1'b0, tex_a[TEX_BITS-1:0]});
      t1_in = $signed({1'b0, tex_b[TEX_WIDTH-1:TEX_BITS]})
            - $signed({1'b0, tex_a[TEX_WIDTH-1:TEX_BITS]});
      s2_in = $signed({1'b0, tex_c[TEX_BITS-1:0]}) - $signed({1'b0, tex_a[TEX_BITS-1:0]});
      t2_in = $signed({1'b0, tex_c[TEX_WIDTH-1:TEX_BITS]})
            - $signed({1'b0, tex_a[TEX_WIDTH-1:TEX_BITS]});
   end

   assign det = (2*TD+1)'(d1_ff) - (2*TD+1)'(d2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff <= p_in;
         q_ff <= q_in;
         s1_ff <= s1_in;
         t1_ff <= t1_in;
         s2_ff <= s2_in;
         t2_ff <= t2_in;
         for (int i = 0; i < 3; i++) begin
            ta_ff[i] <= PW'(p_ff[i]) * PW'(t2_ff);
            tb_ff[i] <= PW'(q_ff[i]) * PW'(t1_ff);
            ba_ff[i] <= PW'(q_ff[i]) * PW'(s1_ff);
            bb_ff[i] <= PW'(p_ff[i]) * PW'(s2_ff);
         end
         d1_ff <= (2*TD)'(s1_ff) * (2*TD)'(t2_ff);
         d2_ff <= (2*TD)'(s2_ff) * (2*TD)'(t1_ff);
         ta3_ff <= ta_ff;
         tb3_ff <= tb_ff;
         ba3_ff <= ba_ff;
         bb3_ff <= bb_ff;
         neg3_ff <= det[2*TD];
         zero3_ff <= (det == '0);
         // a negative determinant flips both vectors: swap the operands
         for (int i = 0; i < 3; i++) begin
            if (neg3_ff) begin
               tan_ff[i] <= VW'(tb3_ff[i]) - VW'(ta3_ff[i]);
               bit_ff[i] <= VW'(bb3_ff[i]) - VW'(ba3_ff[i]);
            end else begin
               tan_ff[i] <= VW'(ta3_ff[i]) - VW'(tb3_ff[i]);
               bit_ff[i] <= VW'(ba3_ff[i]) - VW'(bb3_ff[i]);
            end
         end
         zero4_ff <= zero3_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         tan_out[i*VW +: VW] = tan_ff[i];
         bit_out[i*VW +: VW] = bit_ff[i];
      end
   end

   assign ctl_out.valid = v4_ff;
   assign ctl_out.det_zero = zero4_ff;

endmodule

// File: hw/rtl/ttb_norm.sv
// normalizer for one vector: magnitude scaling, pipelined square root,
// pipelined divide by the length and sign restore; depends on ttb_pkg
module ttb_norm #(
   parameter int COMPONENT_BITS = ttb_pkg::COMPONENT_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  adv,
   input  logic [3*(COMPONENT_BITS+ttb_pkg::TAN_GROWTH)-1:0] vec_in,
   output logic [ttb_pkg::VEC_WIDTH-1:0]         vec_out,
   output logic                                  zero_out
);
   import ttb_pkg::*;

   localparam int VW = COMPONENT_BITS + TAN_GROWTH;
   localparam int MW = VW;
   localparam int SH_N = (MW > MAG_BITS) ? MW - MAG_BITS : 0;
   localparam int SHW = (SH_N > 0) ? $clog2(SH_N + 1) : 1;
   localparam int GEW = (SH_N > 0) ? SH_N : 1;
   localparam int XW = (MW > MAG_BITS) ? MW : MAG_BITS;
   localparam int QW = DIV_STEPS;

   // stage a: magnitudes and signs
   logic [MW-1:0] mag_a_ff [3];
   logic [2:0]    neg_a_ff;
   // stage b: shift count
   logic [MW-1:0] mag_b_ff [3];
   logic [2:0]    neg_b_ff;
   logic [GEW-1:0] ge_b;
   logic [MW-1:0] mag_or;
   logic [SHW-1:0] shift_b_ff;
   // stage c: scaled magnitudes
   logic [MAG_BITS-1:0] sm_c_ff [3];
   logic [2:0]          neg_c_ff;
   // stage d: squares
   logic [2*MAG_BITS-1:0] sq_d_ff [3];
   logic [MAG_BITS-1:0]   sm_d_ff [3];
   logic [2:0]            neg_d_ff;

   // square root stages, index 0 is the sum of squares
   logic [SUM_BITS-1:0] rt_n_ff [0:SQRT_STEPS];
   logic [SUM_BITS-1:0] rt_r_ff [0:SQRT_STEPS];
   logic [MAG_BITS-1:0] rt_m_ff [0:SQRT_STEPS][3];
   logic [2:0]          rt_neg_ff [0:SQRT_STEPS];
   logic                rt_z_ff [0:SQRT_STEPS];

   // divide stages, index 0 is the loaded numerator
   logic [NUM_BITS-1:0] dv_rem_ff [0:DIV_STEPS][3];
   logic [QW-1:0]       dv_q_ff [0:DIV_STEPS][3];
   logic [LEN_BITS-1:0] dv_len_ff [0:DIV_STEPS];
   logic [2:0]          dv_neg_ff [0:DIV_STEPS];
   logic                dv_z_ff [0:DIV_STEPS];

   logic [ttb_pkg::VEC_WIDTH-1:0] vec_ff;
   logic                          zero_ff;

   assign mag_or = mag_a_ff[0] | mag_a_ff[1] | mag_a_ff[2];

   // one flag per possible shift: any magnitude at or above 2^(30+s)
   always_comb begin
      ge_b = '0;
      for (int s = 0; s < SH_N; s++) begin
         ge_b[s] = ((XW'(mag_or) >> (MAG_BITS + s)) != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            neg_a_ff[i] <= vec_in[i*VW + VW - 1];
            mag_a_ff[i] <= vec_in[i*VW + VW - 1] ? MW'(-$signed(vec_in[i*VW +: VW]))
                                                  : MW'(vec_in[i*VW +: VW]);
         end
         mag_b_ff <= mag_a_ff;
         neg_b_ff <= neg_a_ff;
         shift_b_ff <= (SH_N > 0) ? SHW'($countones(ge_b)) : '0;
         for (int i = 0; i < 3; i++) begin
            sm_c_ff[i] <= MAG_BITS'(XW'(mag_b_ff[i]) >> shift_b_ff);
         end
         neg_c_ff <= neg_b_ff;
         for (int i = 0; i < 3; i++) begin
            sq_d_ff[i] <= (2*MAG_BITS)'(sm_c_ff[i]) * (2*MAG_BITS)'(sm_c_ff[i]);
         end
         sm_d_ff <= sm_c_ff;
         neg_d_ff <= neg_c_ff;
         rt_n_ff[0] <= SUM_BITS'(sq_d_ff[0]) + SUM_BITS'(sq_d_ff[1]) + SUM_BITS'(sq_d_ff[2]);
         rt_r_ff[0] <= '0;
         rt_m_ff[0] <= sm_d_ff;
         rt_neg_ff[0] <= neg_d_ff;
         rt_z_ff[0] <= (sm_d_ff[0] == '0) && (sm_d_ff[1] == '0) && (sm_d_ff[2] == '0);
      end
   end

   // one root bit per stage
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      logic [SUM_BITS-1:0] bitv;
      logic [SUM_BITS:0]   trial;
      logic                take;
      assign bitv = SUM_BITS'(1) << (SUM_BITS - 2 - 2 * k);
      assign trial = {1'b0, rt_r_ff[k]} + {1'b0, bitv};
      assign take = ({1'b0, rt_n_ff[k]} >= trial);
      always_ff @(posedge clock) begin
         if (adv) begin
            rt_n_ff[k+1] <= take ? rt_n_ff[k] - trial[SUM_BITS-1:0] : rt_n_ff[k];
            rt_r_ff[k+1] <= take ? (rt_r_ff[k] >> 1) + bitv : (rt_r_ff[k] >> 1);
            rt_m_ff[k+1] <= rt_m_ff[k];
            rt_neg_ff[k+1] <= rt_neg_ff[k];
            rt_z_ff[k+1] <= rt_z_ff[k];
         end
      end
   end

   // numerator m * 2^15 + len, divisor 2 * len
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            dv_rem_ff[0][i] <= (NUM_BITS'(rt_m_ff[SQRT_STEPS][i]) << DIV_STEPS)
                             + NUM_BITS'(rt_r_ff[SQRT_STEPS][LEN_BITS-1:0]);
            dv_q_ff[0][i] <= '0;
         end
         dv_len_ff[0] <= rt_r_ff[SQRT_STEPS][LEN_BITS-1:0];
         dv_neg_ff[0] <= rt_neg_ff[SQRT_STEPS];
         dv_z_ff[0] <= rt_z_ff[SQRT_STEPS];
      end
   end

   // one quotient bit per stage, msb first
   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      logic [NUM_BITS-1:0] dsh;
      assign dsh = NUM_BITS'(dv_len_ff[j]) << (DIV_STEPS - j);
      always_ff @(posedge clock) begin
         if (adv) begin
            for (int i = 0; i < 3; i++) begin
               if (dv_rem_ff[j][i] >= dsh) begin
                  dv_rem_ff[j+1][i] <= dv_rem_ff[j][i] - dsh;
                  dv_q_ff[j+1][i] <= dv_q_ff[j][i] | (QW'(1) << (DIV_STEPS - 1 - j));
               end else begin
                  dv_rem_ff[j+1][i] <= dv_rem_ff[j][i];
                  dv_q_ff[j+1][i] <= dv_q_ff[j][i];
               end
            end
            dv_len_ff[j+1] <= dv_len_ff[j];
            dv_neg_ff[j+1] <= dv_neg_ff[j];
            dv_z_ff[j+1] <= dv_z_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            vec_ff[i*OUT_BITS +: OUT_BITS] <= dv_neg_ff[DIV_STEPS][i]
               ? OUT_BITS'(-OUT_BITS'(dv_q_ff[DIV_STEPS][i]))
               : OUT_BITS'(dv_q_ff[DIV_STEPS][i]);
         end
         zero_ff <= dv_z_ff[DIV_STEPS];
      end
   end

   assign vec_out = vec_ff;
   assign zero_out = zero_ff;

endmodule

// File: hw/rtl/triangle_tangent_basis.sv
// Triangle tangent / bitangent basis, fully pipelined.
// Request channel (req_valid / req_stall) carries three vertex positions
// (x,y,z signed Q11.4 packed, x low) and three texcoords (s low, t high).
// Response channel (rsp_valid / rsp_stall) returns the unit tangent and
// bitangent as packed signed Q1.14 components, and a degenerate flag that
// is set, with both vectors zero, when the texcoord determinant or either
// vector is zero.
// An accepted request passes 4 front stages, 53 normalizer stages (31 for
// the square root, one root bit each, and 15 for the divide, one quotient
// bit each) and the output register on the way to its response.
// Throughput is one request per cycle. Every stage moves together; while a
// valid response sits stalled the whole pipe holds, and req_stall follows,
// so nothing is dropped or repeated. Bubbles ride along as invalid slots.
// Synchronous reset clears all valid bits; data registers are not reset.
// depends on ttb_pkg, ttb_front, ttb_norm
module triangle_tangent_basis #(
   parameter int COMPONENT_BITS = ttb_pkg::COMPONENT_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ttb_pkg::POS_WIDTH-1:0] req_pos_a,
   input  logic [ttb_pkg::POS_WIDTH-1:0] req_pos_b,
   input  logic [ttb_pkg::POS_WIDTH-1:0] req_pos_c,
   input  logic [ttb_pkg::TEX_WIDTH-1:0] req_tex_a,
   input  logic [ttb_pkg::TEX_WIDTH-1:0] req_tex_b,
   input  logic [ttb_pkg::TEX_WIDTH-1:0] req_tex_c,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ttb_pkg::VEC_WIDTH-1:0] rsp_tangent_vec,
   output logic [ttb_pkg::VEC_WIDTH-1:0] rsp_bitangent_vec,
   output logic                          rsp_degenerate
);
   import ttb_pkg::*;

   localparam int VW = COMPONENT_BITS + TAN_GROWTH;

   logic          adv;
   ttb_ctl_type   front_ctl;
   ttb_ctl_type   ctl_ff [0:NORM_LAT-1];
   logic [3*VW-1:0] tan_raw, bit_raw;
   logic [VEC_WIDTH-1:0] tan_unit, bit_unit;
   logic          tan_zero, bit_zero, degen;

   logic                 rsp_valid_ff, rsp_degenerate_ff;
   logic [VEC_WIDTH-1:0] rsp_tangent_ff, rsp_bitangent_ff;

   assign adv = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   ttb_front #(.COMPONENT_BITS(COMPONENT_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_valid),
      .pos_a    (req_pos_a),
      .pos_b    (req_pos_b),
      .pos_c    (req_pos_c),
      .tex_a    (req_tex_a),
      .tex_b    (req_tex_b),
      .tex_c    (req_tex_c),
      .ctl_out  (front_ctl),
      .tan_out  (tan_raw),
      .bit_out  (bit_raw)
   );

   ttb_norm #(.COMPONENT_BITS(COMPONENT_BITS)) u_norm_tan (
      .clock    (clock),
      .adv      (adv),
      .vec_in   (tan_raw),
      .vec_out  (tan_unit),
      .zero_out (tan_zero)
   );

   ttb_norm #(.COMPONENT_BITS(COMPONENT_BITS)) u_norm_bit (
      .clock    (clock),
      .adv      (adv),
      .vec_in   (bit_raw),
      .vec_out  (bit_unit),
      .zero_out (bit_zero)
   );

   // valid and determinant flag ride alongside the normalizers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NORM_LAT; k++) begin
            ctl_ff[k] <= '0;
         end
      end else if (adv) begin
         ctl_ff[0] <= front_ctl;
         for (int k = 1; k < NORM_LAT; k++) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
      end
   end

   assign degen = ctl_ff[NORM_LAT-1].det_zero || tan_zero || bit_zero;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= ctl_ff[NORM_LAT-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_degenerate_ff <= degen;
         rsp_tangent_ff <= degen ? '0 : tan_unit;
         rsp_bitangent_ff <= degen ? '0 : bit_unit;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_degenerate = rsp_degenerate_ff;
   assign rsp_tangent_vec = rsp_tangent_ff;
   assign rsp_bitangent_vec = rsp_bitangent_ff;

endmodule

// File: hw/rtl/ttb_checker.sv
// port-level checks for triangle_tangent_basis, attached by bind
// depends on ttb_pkg and the top level's ports
module ttb_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [ttb_pkg::VEC_WIDTH-1:0] rsp_tangent_vec,
   input logic [ttb_pkg::VEC_WIDTH-1:0] rsp_bitangent_vec,
   input logic                          rsp_degenerate
);

   // no response right after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a degenerate triangle gives zero vectors
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_tangent_vec == '0 && rsp_bitangent_vec == '0)
      else $error("degenerate response with nonzero vectors");

   // the request side is held back only by a stalled response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled response");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_tangent_vec)
         && $stable(rsp_bitangent_vec) && $stable(rsp_degenerate))
      else $error("stalled response changed");

endmodule

bind triangle_tangent_basis ttb_checker u_ttb_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_tangent_vec   (rsp_tangent_vec),
   .rsp_bitangent_vec (rsp_bitangent_vec),
   .rsp_degenerate    (rsp_degenerate)
);
